// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- hw/rtl/lrucb_pkg.sv -----
`default_nettype none
package lrucb_pkg;

  localparam logic [1:0] CMD_STORE = 2'd0;
  localparam logic [1:0] CMD_GET   = 2'd1;
  localparam logic [1:0] CMD_EVICT = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam int unsigned ADDR_W = 4;
  localparam logic REG_ENTRY_LIMIT = 1'b0;
  localparam logic REG_BYTE_BUDGET = 1'b1;

  localparam logic [6:0]  LIMIT_RESET  = 7'd64;
  localparam logic [36:0] BUDGET_RESET = 37'd1073741824;
  localparam logic [36:0] TOTAL_MAX    = 37'h1_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] entry_key;
    logic [23:0] payload_words;
    logic [31:0] tokens;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] found_tokens;
    logic [25:0] found_bytes;
    logic [31:0] found_hits;
    logic        inserted;
    logic [6:0]  evicted_count;
    logic [6:0]  live_entries;
    logic [32:0] live_bytes;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  entry_limit;
    logic [36:0] byte_budget;
  } cfg_t;

endpackage
`default_nettype wire

// ----- hw/rtl/lrucb_cfg.sv -----
`default_nettype none
module lrucb_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [lrucb_pkg::ADDR_W-1:0] paddr,
  input  wire logic [63:0]                pwdata,
  output logic [63:0]                     prdata,
  output logic                            pready,
  output lrucb_pkg::cfg_t                 cfg
);

  lrucb_pkg::cfg_t cfg_r;

  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.entry_limit <= lrucb_pkg::LIMIT_RESET;
      cfg_r.byte_budget <= lrucb_pkg::BUDGET_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[3] == lrucb_pkg::REG_ENTRY_LIMIT) cfg_r.entry_limit <= pwdata[6:0];
      else cfg_r.byte_budget <= pwdata[36:0];
    end
  end

  always_comb begin
    if (paddr[3] == lrucb_pkg::REG_BYTE_BUDGET) prdata = {27'd0, cfg_r.byte_budget};
    else prdata = {57'd0, cfg_r.entry_limit};
  end

endmodule
`default_nettype wire

// ----- hw/rtl/lru_cache_with_byte_budget_top.sv -----
// LRU table with an entry limit and a byte budget, held in one synchronous entry memory.
// Every command but clear walks the memory one slot a cycle. A get or evict scans for the
// key and, on a hit, makes a second scan to move the other ranks; a store first runs one
// scan for the oldest rank per eviction, then a scan for the key and, if that misses, a
// scan that ages every rank and finds a free slot before it inserts. busy is high while a
// command runs; the result appears on out_item for exactly one cycle with out_valid and
// cannot be held off, and the next command may start in that same cycle.
`default_nettype none
`include "assert_macros.svh"
module lru_cache_with_byte_budget_top #(
  parameter int unsigned NUM_SLOTS = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire lrucb_pkg::in_item_t          in_item,
  output logic                              out_valid,
  output lrucb_pkg::out_item_t              out_item,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lrucb_pkg::ADDR_W-1:0] paddr,
  input  wire logic [63:0]                  pwdata,
  output logic [63:0]                       prdata,
  output logic                              pready
);

  localparam int unsigned IW = $clog2(NUM_SLOTS);
  localparam int unsigned CW = $clog2(NUM_SLOTS + 1);
  localparam int unsigned LW = (CW > 7) ? CW : 7;

  typedef struct packed {
    logic [63:0]   key;
    logic [25:0]   bytes;
    logic [31:0]   tokens;
    logic [31:0]   hits;
    logic [IW-1:0] rec;
  } entry_t;

  typedef enum logic [2:0] {S_IDLE, S_CHK, S_OLD, S_FIND, S_PASS, S_PEND, S_RESP} state_t;
  typedef enum logic [1:0] {P_INS, P_RECENT, P_REMOVE} pass_t;

  lrucb_pkg::cfg_t cfg;

  lrucb_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  state_t              state_r;
  pass_t               mode_r;
  lrucb_pkg::in_item_t item_r;
  lrucb_pkg::out_item_t out_item_r;
  logic                out_valid_r;
  logic [NUM_SLOTS-1:0] valid_r;
  logic [CW-1:0]       count_r;
  logic [32:0]         total_r;
  logic [CW-1:0]       idx_r;
  logic                q_vld_r;
  logic [IW-1:0]       q_idx_r;
  logic [IW-1:0]       slot_r;
  logic [IW-1:0]       ref_rec_r;
  logic [IW-1:0]       free_r;
  logic                free_ok_r;
  entry_t              ent_r;
  entry_t              mem_q_r;
  logic                found_r;
  logic                ins_r;
  logic [6:0]          evicted_r;
  logic [31:0]         ftok_r;
  logic [25:0]         fbytes_r;
  logic [31:0]         fhits_r;

  entry_t mem [NUM_SLOTS];

  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;
  logic          q_hit;
  logic          q_last;
  logic          pass_cond;
  logic [25:0]   item_bytes;
  logic [36:0]   sum_bytes;
  logic [36:0]   budget;
  logic [LW-1:0] limit;
  logic          need_evict;
  logic [IW-1:0] old_rec;
  logic [31:0]   hits_inc;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign item_bytes = {item_r.payload_words, 2'b00};
  assign sum_bytes  = {4'd0, total_r} + {11'd0, item_bytes};
  assign budget     = (cfg.byte_budget > lrucb_pkg::TOTAL_MAX) ? lrucb_pkg::TOTAL_MAX
                                                                : cfg.byte_budget;
  assign limit      = (LW'(cfg.entry_limit) > LW'(NUM_SLOTS)) ? LW'(NUM_SLOTS)
                                                              : LW'(cfg.entry_limit);
  assign need_evict = (count_r != '0) &&
                      ((LW'(count_r) >= limit) || (sum_bytes > budget));
  assign old_rec    = IW'(count_r - CW'(1));
  assign hits_inc   = (ent_r.hits == '1) ? ent_r.hits : ent_r.hits + 32'd1;

  assign q_hit  = valid_r[q_idx_r];
  assign q_last = (q_idx_r == IW'(NUM_SLOTS - 1));

  assign rd_en   = ((state_r == S_OLD) || (state_r == S_FIND) || (state_r == S_PASS)) &&
                   (idx_r < CW'(NUM_SLOTS));
  assign rd_addr = idx_r[IW-1:0];

  always_comb begin
    case (mode_r)
      P_INS:    pass_cond = 1'b1;
      P_RECENT: pass_cond = (mem_q_r.rec < ref_rec_r);
      P_REMOVE: pass_cond = (mem_q_r.rec > ref_rec_r);
      default:  pass_cond = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = q_idx_r;
    wr_data = mem_q_r;
    if (state_r == S_PASS) begin
      wr_en = q_vld_r && q_hit && pass_cond;
      if (mode_r == P_REMOVE) wr_data.rec = mem_q_r.rec - IW'(1);
      else wr_data.rec = mem_q_r.rec + IW'(1);
    end else if (state_r == S_PEND) begin
      if (mode_r == P_INS) begin
        wr_en   = 1'b1;
        wr_addr = free_r;
        wr_data = '{key: item_r.entry_key, bytes: item_bytes, tokens: item_r.tokens,
                    hits: 32'd0, rec: '0};
      end else if (mode_r == P_RECENT) begin
        wr_en        = 1'b1;
        wr_addr      = slot_r;
        wr_data      = ent_r;
        wr_data.hits = hits_inc;
        wr_data.rec  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) mem_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      count_r     <= '0;
      total_r     <= '0;
      q_vld_r     <= 1'b0;
      idx_r       <= '0;
      free_ok_r   <= 1'b0;
      mode_r      <= P_INS;
    end else begin
      out_valid_r <= 1'b0;
      q_vld_r     <= rd_en;
      if (rd_en) begin
        idx_r   <= idx_r + CW'(1);
        q_idx_r <= rd_addr;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            item_r    <= in_item;
            found_r   <= 1'b0;
            ins_r     <= 1'b0;
            evicted_r <= '0;
            ftok_r    <= '0;
            fbytes_r  <= '0;
            fhits_r   <= '0;
            idx_r     <= '0;
            q_vld_r   <= 1'b0;
            case (in_item.cmd)
              lrucb_pkg::CMD_CLEAR: begin
                valid_r <= '0;
                count_r <= '0;
                total_r <= '0;
                state_r <= S_RESP;
              end
              lrucb_pkg::CMD_STORE: state_r <= S_CHK;
              default: state_r <= S_FIND;
            endcase
          end
        end
        S_CHK: begin
          idx_r   <= '0;
          q_vld_r <= 1'b0;
          state_r <= need_evict ? S_OLD : S_FIND;
        end
        S_OLD: begin
          // the oldest entry holds the top rank, so no other rank moves
          if (q_vld_r && q_hit && (mem_q_r.rec == old_rec)) begin
            valid_r[q_idx_r] <= 1'b0;
            total_r   <= total_r - {7'd0, mem_q_r.bytes};
            count_r   <= count_r - CW'(1);
            evicted_r <= evicted_r + 7'd1;
            state_r   <= S_CHK;
          end
        end
        S_FIND: begin
          if (q_vld_r && q_hit && (mem_q_r.key == item_r.entry_key)) begin
            idx_r     <= '0;
            q_vld_r   <= 1'b0;
            slot_r    <= q_idx_r;
            ent_r     <= mem_q_r;
            ref_rec_r <= mem_q_r.rec;
            case (item_r.cmd)
              lrucb_pkg::CMD_GET: begin
                mode_r  <= P_RECENT;
                state_r <= S_PASS;
              end
              lrucb_pkg::CMD_EVICT: begin
                valid_r[q_idx_r] <= 1'b0;
                total_r <= total_r - {7'd0, mem_q_r.bytes};
                count_r <= count_r - CW'(1);
                found_r <= 1'b1;
                mode_r  <= P_REMOVE;
                state_r <= S_PASS;
              end
              default: state_r <= S_RESP;
            endcase
          end else if (q_vld_r && q_last) begin
            idx_r   <= '0;
            q_vld_r <= 1'b0;
            if (item_r.cmd == lrucb_pkg::CMD_STORE) begin
              mode_r    <= P_INS;
              free_ok_r <= 1'b0;
              state_r   <= S_PASS;
            end else begin
              state_r <= S_RESP;
            end
          end
        end
        S_PASS: begin
          if (q_vld_r) begin
            if ((mode_r == P_INS) && !q_hit && !free_ok_r) begin
              free_r    <= q_idx_r;
              free_ok_r <= 1'b1;
            end
            if (q_last) state_r <= S_PEND;
          end
        end
        S_PEND: begin
          if (mode_r == P_INS) begin
            valid_r[free_r] <= 1'b1;
            total_r <= total_r + {7'd0, item_bytes};
            count_r <= count_r + CW'(1);
            ins_r   <= 1'b1;
          end else if (mode_r == P_RECENT) begin
            found_r  <= 1'b1;
            ftok_r   <= ent_r.tokens;
            fbytes_r <= ent_r.bytes;
            fhits_r  <= hits_inc;
          end
          state_r <= S_RESP;
        end
        S_RESP: begin
          out_valid_r <= 1'b1;
          out_item_r  <= '{found: found_r, found_tokens: ftok_r, found_bytes: fbytes_r,
                           found_hits: fhits_r, inserted: ins_r, evicted_count: evicted_r,
                           live_entries: 7'(count_r), live_bytes: total_r};
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_out_idle, out_valid |-> !busy, "result shown while busy")
  `ASSERT_CLK(a_count_max, count_r <= CW'(NUM_SLOTS), "entry count above slot count")
  `ASSERT_CLK(a_empty_bytes, (count_r == '0) |-> (total_r == '0), "bytes held with no entry")
  `ASSERT_CLK(a_clear, (start && !busy && (in_item.cmd == lrucb_pkg::CMD_CLEAR)) |=> (count_r == '0), "clear left entries")
  `ASSERT_ALWAYS(a_reset, !rst_n |=> !out_valid, "result during reset")

endmodule
`default_nettype wire
